// File: design/tcst_pkg.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker package
// Shared types, constants and codes of the connection state tracker.
// ----------------------------------------------------------------------------
package tcst_pkg;

	localparam int CONN_ENTRIES = 1024;
	localparam int ADDR_W       = $clog2(CONN_ENTRIES);
	localparam int IDX_W        = 10;
	localparam int TIME_W       = 48;
	localparam int TMO_W        = 20;
	localparam int PROD_W       = 40;
	localparam int CFG_AW       = 4;

	localparam logic [TMO_W-1:0] US_PER_S = 20'd1000000;

	localparam logic [1:0] MODE_PKT  = 2'd0;
	localparam logic [1:0] MODE_OPEN = 2'd1;
	localparam logic [1:0] MODE_POLL = 2'd2;

	localparam logic [1:0] REG_HANDSHAKE = 2'd0;
	localparam logic [1:0] REG_ESTAB     = 2'd1;
	localparam logic [1:0] REG_ACTIVE    = 2'd2;
	localparam logic [1:0] REG_PASSIVE   = 2'd3;

	localparam int FL_FIN = 0;
	localparam int FL_SYN = 1;
	localparam int FL_RST = 2;
	localparam int FL_ACK = 4;

	typedef enum logic [4:0] {
		ST_NONE        = 5'd0,
		ST_RST_SEEN    = 5'd1,
		ST_SYN_SENT    = 5'd2,
		ST_SYN_RECD    = 5'd3,
		ST_ACK_WAIT    = 5'd4,
		ST_ESTAB       = 5'd5,
		ST_FIN_WAIT_1  = 5'd6,
		ST_FIN_WAIT_2  = 5'd7,
		ST_CLOSING_1   = 5'd8,
		ST_CLOSING_2   = 5'd9,
		ST_CLOSING     = 5'd10,
		ST_CLOSE_WAIT_1 = 5'd11,
		ST_CLOSE_WAIT  = 5'd12,
		ST_LAST_ACK_1  = 5'd13,
		ST_LAST_ACK    = 5'd14,
		ST_LAST_ACK_2  = 5'd15,
		ST_CLOSED      = 5'd16,
		ST_TIMEDOUT    = 5'd17
	} conn_state_t;

	typedef enum logic [2:0] {
		KIND_PKT,
		KIND_OPEN,
		KIND_POLL,
		KIND_NOP,
		KIND_OOR
	} item_kind_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_CALC,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [IDX_W-1:0]  conn_index;
		logic [7:0]        flag_bits;
		logic              inbound;
		logic [TIME_W-1:0] now_us;
	} in_word_t;

	typedef struct packed {
		logic [4:0] conn_state;
		logic [4:0] transition_code;
		logic       is_terminated;
		logic       expired;
	} out_word_t;

	typedef struct packed {
		item_kind_t        kind;
		logic [IDX_W-1:0]  idx;
		logic [7:0]        flags;
		logic              inbound;
		logic [TIME_W-1:0] now_us;
	} cls_item_t;

	typedef struct packed {
		logic [TMO_W-1:0] handshake;
		logic [TMO_W-1:0] estab;
		logic [TMO_W-1:0] active;
		logic [TMO_W-1:0] passive;
	} tmo_cfg_t;

	typedef struct packed {
		logic [4:0]        state;
		logic              term;
		logic [TIME_W-1:0] last;
	} entry_t;

endpackage

// File: design/tcst_cfg.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker configuration registers
// Holds the four timeout registers behind an APB-style port.
// ----------------------------------------------------------------------------
module tcst_cfg import tcst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output tmo_cfg_t          cfg
);

	tmo_cfg_t   cfg_q;
	logic [1:0] reg_sel;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.handshake <= 20'd12;
			cfg_q.estab     <= 20'd30;
			cfg_q.active    <= 20'd15;
			cfg_q.passive   <= 20'd10;
		end else if (wr_en) begin
			case (reg_sel)
				REG_HANDSHAKE: cfg_q.handshake <= pwdata[TMO_W-1:0];
				REG_ESTAB:     cfg_q.estab     <= pwdata[TMO_W-1:0];
				REG_ACTIVE:    cfg_q.active    <= pwdata[TMO_W-1:0];
				REG_PASSIVE:   cfg_q.passive   <= pwdata[TMO_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_HANDSHAKE: prdata = {12'd0, cfg_q.handshake};
			REG_ESTAB:     prdata = {12'd0, cfg_q.estab};
			REG_ACTIVE:    prdata = {12'd0, cfg_q.active};
			REG_PASSIVE:   prdata = {12'd0, cfg_q.passive};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

// File: design/tcst_front.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker front end
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tcst_front import tcst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  in_word,
	input  logic      clearing,
	output logic      q_valid,
	output cls_item_t q_item,
	input  logic      q_pop
);

	cls_item_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	cls_item_t  cls;

	always_comb begin
		cls.idx     = in_word.conn_index;
		cls.flags   = in_word.flag_bits;
		cls.inbound = in_word.inbound;
		cls.now_us  = in_word.now_us;
		if ({1'b0, in_word.conn_index} >= (IDX_W+1)'(CONN_ENTRIES)) begin
			cls.kind = KIND_OOR;
		end else begin
			case (in_word.mode)
				MODE_PKT:  cls.kind = KIND_PKT;
				MODE_OPEN: cls.kind = KIND_OPEN;
				MODE_POLL: cls.kind = KIND_POLL;
				default:   cls.kind = KIND_NOP;
			endcase
		end
	end

	assign full    = clearing || (count_q == 2'd2);
	assign do_push = push && !full;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, q_pop};
		end
	end

endmodule

// File: design/tcst_back.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker back end
// Read-modify-write sequencer over the connection table and result register.
// ----------------------------------------------------------------------------
module tcst_back import tcst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tmo_cfg_t  cfg,
	input  logic      q_valid,
	input  cls_item_t q_item,
	output logic      q_pop,
	output logic      clearing,
	output logic      empty,
	input  logic      pop,
	output out_word_t out_word
);

	function automatic logic [9:0] next_state(input logic [4:0] old, input logic [7:0] f,
						 input logic in);
		logic       fin;
		logic       syn;
		logic       rst;
		logic       ack;
		logic [4:0] s;
		logic [4:0] t;
		fin = f[FL_FIN];
		syn = f[FL_SYN];
		rst = f[FL_RST];
		ack = f[FL_ACK];
		s   = old;
		t   = 5'd0;
		if (rst && old != ST_ESTAB) begin
			s = ST_RST_SEEN; t = 5'd8;
		end else begin
			case (old)
				ST_NONE: begin
					if (syn) begin
						if (in) begin s = ST_SYN_RECD; t = 5'd1; end
						else begin s = ST_SYN_SENT; t = 5'd2; end
					end
				end
				ST_SYN_RECD: begin
					if (!in) begin
						if (ack && syn) begin s = ST_ACK_WAIT; t = 5'd3; end
						else if (fin) begin s = ST_FIN_WAIT_1; t = 5'd29; end
					end
				end
				ST_ACK_WAIT: begin
					if (in) begin
						if (ack && fin) begin s = ST_CLOSE_WAIT_1; t = 5'd7; end
						else if (ack) begin s = ST_ESTAB; t = 5'd6; end
					end else if (fin) begin
						s = ST_FIN_WAIT_1; t = 5'd30;
					end
				end
				ST_SYN_SENT: begin
					if (in) begin
						if (ack && syn) begin
							if (fin) begin s = ST_CLOSE_WAIT_1; t = 5'd31; end
							else begin s = ST_ESTAB; t = 5'd5; end
						end else if (syn) begin
							s = ST_SYN_RECD; t = 5'd4;
						end
					end
				end
				ST_ESTAB: begin
					if (rst) begin s = ST_CLOSED; t = 5'd20; end
					else if (fin) begin
						if (in) begin s = ST_CLOSE_WAIT_1; t = 5'd10; end
						else begin s = ST_FIN_WAIT_1; t = 5'd11; end
					end
				end
				ST_FIN_WAIT_1: begin
					if (in) begin
						if (ack) begin
							if (fin) begin s = ST_CLOSING_2; t = 5'd16; end
							else begin s = ST_FIN_WAIT_2; t = 5'd13; end
						end else if (fin) begin
							s = ST_CLOSING_1; t = 5'd12;
						end
					end
				end
				ST_FIN_WAIT_2: begin
					if (in && fin) begin s = ST_CLOSING_2; t = 5'd14; end
				end
				ST_CLOSING_1: begin
					if (ack) begin
						if (in) begin s = ST_CLOSING_2; t = 5'd15; end
						else begin s = ST_CLOSING; t = 5'd17; end
					end
				end
				ST_CLOSING_2: begin
					if (!in && ack) begin s = ST_CLOSED; t = 5'd19; end
				end
				ST_CLOSING: begin
					if (in && ack) begin s = ST_CLOSED; t = 5'd18; end
				end
				ST_CLOSE_WAIT_1: begin
					if (!in) begin
						if (ack) begin
							if (fin) begin s = ST_LAST_ACK; t = 5'd25; end
							else begin s = ST_CLOSE_WAIT; t = 5'd22; end
						end else if (fin) begin
							s = ST_LAST_ACK_1; t = 5'd21;
						end
					end
				end
				ST_CLOSE_WAIT: begin
					if (!in && fin) begin s = ST_LAST_ACK; t = 5'd23; end
				end
				ST_LAST_ACK_1: begin
					if (ack) begin
						if (in) begin s = ST_LAST_ACK_2; t = 5'd26; end
						else begin s = ST_LAST_ACK; t = 5'd24; end
					end
				end
				ST_LAST_ACK: begin
					if (in && ack) begin s = ST_CLOSED; t = 5'd28; end
				end
				ST_LAST_ACK_2: begin
					if (!in && ack) begin s = ST_CLOSED; t = 5'd27; end
				end
				default: begin
					s = old;
				end
			endcase
		end
		return {s, t};
	endfunction

	entry_t            mem [CONN_ENTRIES];
	back_state_t       state_q;
	back_state_t       state_nx;
	logic [ADDR_W-1:0] clr_q;
	cls_item_t         item_q;
	entry_t            rd_q;
	entry_t            ent_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [TMO_W-1:0]  secs;
	logic              res_valid_q;
	out_word_t         res_q;
	logic              exec_en;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	entry_t            mem_wd;
	logic [ADDR_W-1:0] rd_addr;
	logic              expd;
	logic              fresh;
	logic [4:0]        base_st;
	logic              base_term;
	logic [9:0]        ns_t;
	logic              ns_term;
	logic              upd_we;
	entry_t            upd;
	out_word_t         res_nx;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_CLEAR: if (clr_q == ADDR_W'(CONN_ENTRIES - 1)) state_nx = BK_IDLE;
			BK_IDLE:  if (q_valid && !res_valid_q) state_nx = BK_READ;
			BK_READ:  state_nx = BK_CALC;
			BK_CALC:  state_nx = BK_EXEC;
			BK_EXEC:  state_nx = BK_IDLE;
			default:  state_nx = BK_CLEAR;
		endcase
	end

	always_comb begin
		clearing = (state_q == BK_CLEAR);
		q_pop    = (state_q == BK_IDLE) && q_valid && !res_valid_q;
		exec_en  = (state_q == BK_EXEC);
	end

	assign rd_addr = item_q.idx[ADDR_W-1:0];

	always_comb begin
		case (conn_state_t'(rd_q.state))
			ST_ESTAB: secs = cfg.estab;
			ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_CLOSING_1, ST_CLOSING_2, ST_CLOSING:
				secs = cfg.active;
			ST_CLOSE_WAIT_1, ST_CLOSE_WAIT, ST_LAST_ACK_1, ST_LAST_ACK, ST_LAST_ACK_2:
				secs = cfg.passive;
			default: secs = cfg.handshake;
		endcase
	end

	always_comb begin
		expd      = {1'b0, item_q.now_us} >
			({1'b0, ent_s2.last} + {{(TIME_W + 1 - PROD_W){1'b0}}, prod_s2});
		fresh     = (item_q.kind == KIND_OPEN) || expd;
		base_st   = fresh ? 5'(ST_NONE) : ent_s2.state;
		base_term = fresh ? 1'b0 : ent_s2.term;
		ns_t      = next_state(base_st, item_q.flags, item_q.inbound);
		ns_term   = base_term || (ns_t[9:5] == ST_RST_SEEN) || (ns_t[9:5] == ST_CLOSED);
		upd       = ent_s2;
		upd_we    = 1'b0;
		res_nx    = '0;
		case (item_q.kind)
			KIND_PKT, KIND_OPEN: begin
				upd_we                 = 1'b1;
				upd.state              = ns_t[9:5];
				upd.term               = ns_term;
				upd.last               = item_q.now_us;
				res_nx.conn_state      = ns_t[9:5];
				res_nx.transition_code = ns_t[4:0];
				res_nx.is_terminated   = ns_term;
				res_nx.expired         = (item_q.kind == KIND_PKT) && expd;
			end
			KIND_POLL: begin
				if (expd) begin
					upd_we    = 1'b1;
					upd.state = ST_TIMEDOUT;
					upd.term  = 1'b1;
				end
				res_nx.conn_state    = upd.state;
				res_nx.is_terminated = upd.term;
				res_nx.expired       = expd;
			end
			KIND_NOP: begin
				res_nx.conn_state    = ent_s2.state;
				res_nx.is_terminated = ent_s2.term;
			end
			default: res_nx = '0;
		endcase
	end

	always_comb begin
		if (clearing) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = exec_en && upd_we;
			mem_wa = rd_addr;
			mem_wd = upd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == BK_CALC) begin
			ent_s2  <= rd_q;
			prod_s2 <= PROD_W'(US_PER_S * secs);
		end
		if (exec_en) begin
			res_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			if (exec_en) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty    = !res_valid_q;
	assign out_word = res_q;

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (mem_we && mem_wd == '0))
		else $error("table clear writes a nonzero entry");

	a_res_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == BK_EXEC))
		else $error("result appeared outside execute step");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == BK_IDLE && !res_valid_q && !clearing))
		else $error("queue popped while busy");

	a_exec_seq: assert property (@(posedge clk) disable iff (!arst_n)
		exec_en |-> $past(state_q == BK_CALC, 1) && $past(state_q == BK_READ, 2))
		else $error("execute step without read and calc steps");

endmodule

// File: design/tcp_connection_state_tracker.sv
// ----------------------------------------------------------------------------
// TCP connection state tracker
// Per-connection TCP observer state machine with state-dependent timeouts.
// ----------------------------------------------------------------------------
// Input words enter through push/full and results leave through empty/pop;
// each accepted word gives exactly one result word, in order. Timeouts are
// set through the APB-style port; the user must write them only while the
// block is idle, as the block itself does not enforce this. A front end
// classifies each word into a two-word queue; the back end runs a
// read-modify-write of the 1024-entry connection table in four steps
// (issue, table read, timeout multiply, compare and update). A result word
// is registered in the compare and update step, and the next word is issued
// only once the result register is free, so the back end issues no new word
// before the last result is popped. After reset the table is cleared one entry
// per cycle while full stays high; configuration writes are taken as usual.
// When the receiver does not pop, the result register holds its word, the
// back end waits and the queue takes up to two more words before full rises.
module tcp_connection_state_tracker import tcst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_word_t          in_word,
	output logic              empty,
	input  logic              pop,
	output out_word_t         out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	tmo_cfg_t  cfg;
	logic      clearing;
	logic      q_valid;
	cls_item_t q_item;
	logic      q_pop;

	tcst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcst_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	tcst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.clearing (clearing),
		.empty    (empty),
		.pop      (pop),
		.out_word (out_word)
	);

endmodule

// File: sim/tb_tcp_connection_state_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP connection state tracker testbench
// Drives packet, open, poll and unused-mode words through the push/full side.
// Each accepted word is run through a local model of the connection table.
// Every popped result word is compared against the oldest predicted word.
// The random phases use random modes, flags and indices, timeouts at
// their extremes, random idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_tcp_connection_state_tracker;
	import tcst_pkg::*;

	localparam int WDOG_LIMIT = 4000;
	localparam int MAX_SHOWN  = 10;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [4:0] TR_NONE = 5'd0, TR_SYN_IN = 5'd1, TR_SYN_OUT = 5'd2,
		TR_RECD_SYNACK = 5'd3, TR_SENT_SYN = 5'd4, TR_SENT_SYNACK = 5'd5,
		TR_WAIT_ACK = 5'd6, TR_WAIT_ACKFIN = 5'd7, TR_RST = 5'd8,
		TR_EST_FIN_IN = 5'd10, TR_EST_FIN_OUT = 5'd11, TR_FW1_FIN = 5'd12,
		TR_FW1_ACK = 5'd13, TR_FW2_FIN = 5'd14, TR_CL1_ACK_IN = 5'd15,
		TR_FW1_ACKFIN = 5'd16, TR_CL1_ACK_OUT = 5'd17, TR_CLOSING_ACK = 5'd18,
		TR_CL2_ACK = 5'd19, TR_EST_RST = 5'd20, TR_CW1_FIN = 5'd21,
		TR_CW1_ACK = 5'd22, TR_CW_FIN = 5'd23, TR_LA1_ACK_OUT = 5'd24,
		TR_CW1_ACKFIN = 5'd25, TR_LA1_ACK_IN = 5'd26, TR_LA2_ACK = 5'd27,
		TR_LA_ACK = 5'd28, TR_RECD_FIN = 5'd29, TR_WAIT_FIN = 5'd30,
		TR_SENT_SYNACKFIN = 5'd31;

	localparam logic [7:0] F_FIN = 8'h01, F_SYN = 8'h02, F_RST = 8'h04, F_ACK = 8'h10;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_word_t    in_word;
	logic        empty;
	logic        pop;
	out_word_t   out_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tcp_connection_state_tracker DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	conn_state_t       tbl_state [CONN_ENTRIES];
	logic              tbl_term  [CONN_ENTRIES];
	logic [TIME_W-1:0] tbl_last  [CONN_ENTRIES];
	logic [TMO_W-1:0]  tmo_secs  [4];

	out_word_t   pending_results[$];
	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_off_cycles;
	int          quiet_cycles;
	logic [TIME_W-1:0] clock_us;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [4:0] next_conn_state(input conn_state_t old,
		input logic [7:0] f, input logic inb, output conn_state_t ns);
		logic fin, syn, rst, ack;
		logic [4:0] tr;
		fin = f[FL_FIN];
		syn = f[FL_SYN];
		rst = f[FL_RST];
		ack = f[FL_ACK];
		ns = old;
		tr = TR_NONE;
		if (rst && old != ST_ESTAB) begin
			ns = ST_RST_SEEN; tr = TR_RST;
		end else begin
			case (old)
				ST_NONE: if (syn) begin
					if (inb) begin ns = ST_SYN_RECD; tr = TR_SYN_IN; end
					else begin ns = ST_SYN_SENT; tr = TR_SYN_OUT; end
				end
				ST_SYN_RECD: if (!inb) begin
					if (ack && syn) begin ns = ST_ACK_WAIT; tr = TR_RECD_SYNACK; end
					else if (fin) begin ns = ST_FIN_WAIT_1; tr = TR_RECD_FIN; end
				end
				ST_ACK_WAIT: if (inb) begin
					if (ack && fin) begin ns = ST_CLOSE_WAIT_1; tr = TR_WAIT_ACKFIN; end
					else if (ack) begin ns = ST_ESTAB; tr = TR_WAIT_ACK; end
				end else if (fin) begin
					ns = ST_FIN_WAIT_1; tr = TR_WAIT_FIN;
				end
				ST_SYN_SENT: if (inb) begin
					if (ack && syn) begin
						if (fin) begin ns = ST_CLOSE_WAIT_1; tr = TR_SENT_SYNACKFIN; end
						else begin ns = ST_ESTAB; tr = TR_SENT_SYNACK; end
					end else if (syn) begin
						ns = ST_SYN_RECD; tr = TR_SENT_SYN;
					end
				end
				ST_ESTAB: if (rst) begin
					ns = ST_CLOSED; tr = TR_EST_RST;
				end else if (fin) begin
					if (inb) begin ns = ST_CLOSE_WAIT_1; tr = TR_EST_FIN_IN; end
					else begin ns = ST_FIN_WAIT_1; tr = TR_EST_FIN_OUT; end
				end
				ST_FIN_WAIT_1: if (inb) begin
					if (ack) begin
						if (fin) begin ns = ST_CLOSING_2; tr = TR_FW1_ACKFIN; end
						else begin ns = ST_FIN_WAIT_2; tr = TR_FW1_ACK; end
					end else if (fin) begin
						ns = ST_CLOSING_1; tr = TR_FW1_FIN;
					end
				end
				ST_FIN_WAIT_2: if (inb && fin) begin ns = ST_CLOSING_2; tr = TR_FW2_FIN; end
				ST_CLOSING_1: if (ack) begin
					if (inb) begin ns = ST_CLOSING_2; tr = TR_CL1_ACK_IN; end
					else begin ns = ST_CLOSING; tr = TR_CL1_ACK_OUT; end
				end
				ST_CLOSING_2: if (!inb && ack) begin ns = ST_CLOSED; tr = TR_CL2_ACK; end
				ST_CLOSING: if (inb && ack) begin ns = ST_CLOSED; tr = TR_CLOSING_ACK; end
				ST_CLOSE_WAIT_1: if (!inb) begin
					if (ack) begin
						if (fin) begin ns = ST_LAST_ACK; tr = TR_CW1_ACKFIN; end
						else begin ns = ST_CLOSE_WAIT; tr = TR_CW1_ACK; end
					end else if (fin) begin
						ns = ST_LAST_ACK_1; tr = TR_CW1_FIN;
					end
				end
				ST_CLOSE_WAIT: if (!inb && fin) begin ns = ST_LAST_ACK; tr = TR_CW_FIN; end
				ST_LAST_ACK_1: if (ack) begin
					if (inb) begin ns = ST_LAST_ACK_2; tr = TR_LA1_ACK_IN; end
					else begin ns = ST_LAST_ACK; tr = TR_LA1_ACK_OUT; end
				end
				ST_LAST_ACK: if (inb && ack) begin ns = ST_CLOSED; tr = TR_LA_ACK; end
				ST_LAST_ACK_2: if (!inb && ack) begin ns = ST_CLOSED; tr = TR_LA2_ACK; end
				default: ;
			endcase
		end
		return tr;
	endfunction

	function automatic logic entry_timed_out(input int idx, input logic [TIME_W-1:0] now);
		logic [TMO_W-1:0] secs;
		logic [63:0] limit_us;
		case (tbl_state[idx])
			ST_ESTAB: secs = tmo_secs[REG_ESTAB];
			ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_CLOSING_1, ST_CLOSING_2, ST_CLOSING:
				secs = tmo_secs[REG_ACTIVE];
			ST_CLOSE_WAIT_1, ST_CLOSE_WAIT, ST_LAST_ACK_1, ST_LAST_ACK, ST_LAST_ACK_2:
				secs = tmo_secs[REG_PASSIVE];
			default: secs = tmo_secs[REG_HANDSHAKE];
		endcase
		limit_us = 64'(tbl_last[idx]) + 64'(secs) * 64'd1000000;
		return 64'(now) > limit_us;
	endfunction

	function automatic out_word_t track_word(input in_word_t w);
		out_word_t r;
		int idx;
		logic fresh;
		conn_state_t ns;
		idx = int'(w.conn_index);
		r = '0;
		if (w.mode == MODE_POLL) begin
			if (entry_timed_out(idx, w.now_us)) begin
				tbl_state[idx] = ST_TIMEDOUT;
				tbl_term[idx] = 1'b1;
				r.expired = 1'b1;
			end
		end else if (w.mode == MODE_PKT || w.mode == MODE_OPEN) begin
			fresh = (w.mode == MODE_OPEN);
			if (!fresh && entry_timed_out(idx, w.now_us)) begin
				fresh = 1'b1;
				r.expired = 1'b1;
			end
			if (fresh) begin
				tbl_state[idx] = ST_NONE;
				tbl_term[idx] = 1'b0;
			end
			tbl_last[idx] = w.now_us;
			r.transition_code = next_conn_state(tbl_state[idx], w.flag_bits, w.inbound, ns);
			if (ns == ST_RST_SEEN || ns == ST_CLOSED)
				tbl_term[idx] = 1'b1;
			tbl_state[idx] = ns;
		end
		r.conn_state = tbl_state[idx];
		r.is_terminated = tbl_term[idx];
		return r;
	endfunction

	// Called at a falling edge; returns at a falling edge with push still high.
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_results.push_back(track_word(w));
		@(negedge clk);
	endtask

	task automatic send_item(input logic [1:0] mode, input logic [IDX_W-1:0] idx,
		input logic [7:0] flags, input logic inb, input logic [TIME_W-1:0] now);
		in_word_t w;
		w.mode = mode;
		w.conn_index = idx;
		w.flag_bits = flags;
		w.inbound = inb;
		w.now_us = now;
		send_word(w);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_timeout(input logic [1:0] reg_sel, input logic [TMO_W-1:0] secs);
		logic [31:0] data;
		data = {12'($urandom_range(4095)), secs};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(reg_sel) << 2;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tmo_secs[reg_sel] = data[TMO_W-1:0];
	endtask

	task automatic set_timeouts(input logic [TMO_W-1:0] hs, input logic [TMO_W-1:0] es,
		input logic [TMO_W-1:0] ac, input logic [TMO_W-1:0] pa);
		drain_results();
		write_timeout(REG_HANDSHAKE, hs);
		write_timeout(REG_ESTAB, es);
		write_timeout(REG_ACTIVE, ac);
		write_timeout(REG_PASSIVE, pa);
	endtask

	task automatic test_handshakes_and_closes();
		clock_us = 48'd5_000_000;
		send_item(MODE_OPEN, 10'd1, F_SYN, 1'b0, clock_us);
		send_item(MODE_PKT, 10'd1, F_SYN | F_ACK, 1'b1, clock_us + 1);
		send_item(MODE_PKT, 10'd1, F_FIN, 1'b0, clock_us + 2);
		send_item(MODE_PKT, 10'd1, F_FIN | F_ACK, 1'b1, clock_us + 3);
		send_item(MODE_PKT, 10'd1, F_ACK, 1'b0, clock_us + 4);
		send_item(MODE_OPEN, 10'd2, F_SYN, 1'b1, clock_us);
		send_item(MODE_PKT, 10'd2, F_SYN | F_ACK, 1'b0, clock_us + 1);
		send_item(MODE_PKT, 10'd2, F_FIN | F_ACK, 1'b1, clock_us + 2);
		send_item(MODE_PKT, 10'd2, F_FIN, 1'b0, clock_us + 3);
		send_item(MODE_PKT, 10'd2, F_ACK, 1'b1, clock_us + 4);
		send_item(MODE_PKT, 10'd2, F_ACK, 1'b0, clock_us + 5);
		send_item(MODE_OPEN, 10'd3, F_RST, 1'b0, clock_us);
		send_item(MODE_PKT, 10'd3, F_SYN, 1'b1, clock_us + 1);
		send_item(MODE_POLL, 10'd3, 8'h00, 1'b0, clock_us + 2);
		send_item(MODE_POLL, 10'd3, 8'hFF, 1'b1, TIME_MAX);
		send_item(MODE_PKT, 10'd3, 8'hFF, 1'b1, TIME_MAX);
		send_item(MODE_PKT, 10'd1023, 8'hFF, 1'b0, 48'd0);
		send_item(2'd3, 10'd1023, 8'hFF, 1'b1, TIME_MAX);
		send_item(MODE_OPEN, 10'd0, 8'h00, 1'b1, TIME_MAX);
		send_item(MODE_POLL, 10'd0, 8'h00, 1'b0, 48'd0);
		send_item(MODE_OPEN, 10'd4, F_SYN | F_ACK, 1'b0, clock_us);
		send_item(MODE_PKT, 10'd4, F_RST, 1'b1, clock_us + 1);
	endtask

	function automatic logic [7:0] pick_flags();
		logic [7:0] f;
		case ($urandom_range(7))
			0: f = F_SYN;
			1: f = F_SYN | F_ACK;
			2: f = F_ACK;
			3: f = F_FIN;
			4: f = F_FIN | F_ACK;
			5: f = F_SYN | F_ACK | F_FIN;
			6: f = ($urandom_range(3) == 0) ? F_RST : F_ACK;
			default: f = 8'h00;
		endcase
		if ($urandom_range(99) < 30)
			f = f | (8'($urandom) & 8'hE8);
		if ($urandom_range(99) < 5)
			f = 8'($urandom);
		return f;
	endfunction

	task automatic test_random_traffic(input int n_items, input logic pressure);
		logic [IDX_W-1:0] pool[8];
		logic [1:0] mode;
		logic [IDX_W-1:0] idx;
		int roll;
		foreach (pool[k])
			pool[k] = IDX_W'($urandom);
		pool[0] = '0;
		pool[1] = '1;
		for (int n = 0; n < n_items; n++) begin
			if (pressure && n == n_items / 3)
				hold_off_cycles = 300;
			roll = $urandom_range(99);
			if (roll < 60) mode = MODE_PKT;
			else if (roll < 78) mode = MODE_OPEN;
			else if (roll < 96) mode = MODE_POLL;
			else mode = 2'd3;
			idx = ($urandom_range(9) == 0) ? IDX_W'($urandom) : pool[$urandom_range(7)];
			if ($urandom_range(99) < 3)
				clock_us = {16'($urandom), 32'($urandom)};
			else if ($urandom_range(99) < 10)
				clock_us = clock_us + 48'($urandom_range(40_000_000));
			else
				clock_us = clock_us + 48'($urandom_range(1_500_000));
			send_item(mode, idx, pick_flags(), 1'($urandom), clock_us);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("tcp_connection_state_tracker verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			pop <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("Unexpected result word %p", out_word);
			end else begin
				want = pending_results.pop_front();
				if (out_word.conn_state !== want.conn_state
					|| out_word.transition_code !== want.transition_code
					|| out_word.is_terminated !== want.is_terminated
					|| out_word.expired !== want.expired) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("Result mismatch: expected %p, got %p", want, out_word);
				end
			end
		end
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		in_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		hold_off_cycles = 0;
		quiet_cycles = 0;
		send_idle_pct = 36;
		recv_idle_pct = 47;
		clock_us = '0;
		tmo_secs[REG_HANDSHAKE] = 20'd12;
		tmo_secs[REG_ESTAB] = 20'd30;
		tmo_secs[REG_ACTIVE] = 20'd15;
		tmo_secs[REG_PASSIVE] = 20'd10;
		for (int k = 0; k < CONN_ENTRIES; k++) begin
			tbl_state[k] = ST_NONE;
			tbl_term[k] = 1'b0;
			tbl_last[k] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_handshakes_and_closes();
		set_timeouts(20'd1, 20'd2, 20'd1, 20'd1);
		test_random_traffic(650, 1'b0);

		send_idle_pct = 47;
		recv_idle_pct = 36;
		set_timeouts(20'd0, 20'd0, 20'd0, 20'd0);
		test_random_traffic(300, 1'b0);
		set_timeouts(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		test_random_traffic(300, 1'b0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_timeouts(20'd3, 20'd12, 20'd2, 20'd1);
		test_random_traffic(650, 1'b1);

		push <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tcp_connection_state_tracker verification clean");
		else
			$display("tcp_connection_state_tracker verification failed");
		$finish;
	end

endmodule
